/* hw/rtl/sis_pkg.sv */
`default_nettype none

package sis_pkg;

    // Set geometry.
    localparam int CAPACITY       = 64;
    localparam int MAX_RANGE_SPAN = 100;
    localparam int DATA_W         = 32;
    localparam int KIND_W         = 3;
    localparam int COUNT_W        = 7;
    localparam int ADDR_W         = $clog2(CAPACITY);
    localparam int CNT_W          = $clog2(CAPACITY + 1);

    // Operation codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RANGE  = 3'd4;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPAN,
        ST_SCAN_START,
        ST_SCAN,
        ST_ACT,
        ST_SHUP,
        ST_WRNEW,
        ST_SHDN,
        ST_RNEXT,
        ST_REPLY
    } state_t;

    // Memory request from the sequencer.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    // Operands for the shared compare unit.
    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } alu_req_t;

    // Compare unit flags: a < b, a == b, a - b above the span limit.
    typedef struct packed {
        logic lt;
        logic eq;
        logic over;
    } alu_res_t;

    // One finished result.
    typedef struct packed {
        logic               present;
        logic [COUNT_W-1:0] count;
        logic               overflow;
        logic               rejected;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/sorted_integer_set_top.sv */
// Sorted integer set: a duplicate-free set of signed 32-bit values kept in
// ascending order, up to 64 entries.
// Input channel (s_): s_tuser carries the operation (lookup, insert, remove,
// clear, range insert); s_tdata carries the value and the range end.
// Result channel (m_): exactly one transfer per input transfer, giving
// whether the value was held, the entry count after the operation, an
// overflow flag for dropped inserts and a flag for refused range inserts.
// One item is worked on at a time; s_tready is high only while idle.
// Entries are scanned in order through one memory read port and one shared
// comparator, one entry per cycle, and shifts move one entry per cycle.
// A lookup scans up to the first entry not below the value; an insert or
// remove then shifts the entries above that point up or down by one.
// A range insert first checks its span, then inserts each value from start
// to end in turn, up to 101 values.
// The result is held in an output register; a stalled receiver holds that
// register, and the next item can be accepted meanwhile, finishing into the
// register once it has been taken.
// Reset clears the entry count and all control state; stored entries are not
// cleared and are never read before being written.
`default_nettype none

module sorted_integer_set_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // value [31:0], range_end [63:32]
    input  wire logic [7:0]  s_tuser,  // kind [2:0], zeros above
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata   // present [0], count [7:1], overflow [8],
                                       // range_rejected [9], zeros above
);

    sis_pkg::ram_req_t                ram_req;
    logic [sis_pkg::DATA_W-1:0]       ram_rd_data;
    sis_pkg::alu_req_t                alu_req;
    sis_pkg::alu_res_t                alu_res;
    logic                             out_free;
    logic                             out_load;
    sis_pkg::result_t                 out_result;
    logic                             m_tvalid_reg, m_tvalid_next;
    sis_pkg::result_t                 m_res_reg, m_res_next;

    sis_ram #(
        .WIDTH (sis_pkg::DATA_W),
        .DEPTH (sis_pkg::CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    sis_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    sis_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (s_tuser[sis_pkg::KIND_W-1:0]),
        .in_value    (s_tdata[31:0]),
        .in_end      (s_tdata[63:32]),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .alu_req     (alu_req),
        .alu_res     (alu_res),
        .out_free    (out_free),
        .out_load    (out_load),
        .out_result  (out_result)
    );

    // Output register: free when empty or when its transfer completes now.
    always_comb begin
        out_free      = !m_tvalid_reg || m_tready;
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_res_next    = out_result;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_res_reg.rejected, m_res_reg.overflow,
                       m_res_reg.count, m_res_reg.present};

endmodule

`default_nettype wire

/* hw/rtl/sis_ram.sv */
`default_nettype none

module sis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sis_alu.sv */
`default_nettype none

module sis_alu (
    input  wire sis_pkg::alu_req_t req,
    output sis_pkg::alu_res_t      res
);

    logic signed [sis_pkg::DATA_W:0] diff;

    // One signed subtract serves both the scan compare and the span check.
    always_comb begin
        diff     = $signed({req.a[sis_pkg::DATA_W-1], req.a})
                 - $signed({req.b[sis_pkg::DATA_W-1], req.b});
        res.lt   = diff[sis_pkg::DATA_W];
        res.eq   = (diff == '0);
        res.over = !diff[sis_pkg::DATA_W]
                 && (diff[sis_pkg::DATA_W-1:0] > sis_pkg::DATA_W'(sis_pkg::MAX_RANGE_SPAN));
    end

endmodule

`default_nettype wire

/* hw/rtl/sis_seq.sv */
`default_nettype none

module sis_seq (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input item.
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [sis_pkg::KIND_W-1:0]     in_kind,
    input  wire logic [sis_pkg::DATA_W-1:0]     in_value,
    input  wire logic [sis_pkg::DATA_W-1:0]     in_end,
    // Memory and compare unit.
    output sis_pkg::ram_req_t                   ram_req,
    input  wire logic [sis_pkg::DATA_W-1:0]     ram_rd_data,
    output sis_pkg::alu_req_t                   alu_req,
    input  wire sis_pkg::alu_res_t              alu_res,
    // Result toward the output register.
    input  wire logic                           out_free,
    output logic                                out_load,
    output sis_pkg::result_t                    out_result
);

    sis_pkg::state_t                   state_reg, state_next;
    logic [sis_pkg::KIND_W-1:0]        kind_reg, kind_next;
    logic [sis_pkg::DATA_W-1:0]        x_reg, x_next;
    logic [sis_pkg::DATA_W-1:0]        e_reg, e_next;
    logic [sis_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [sis_pkg::CNT_W-1:0]         ptr_reg, ptr_next;
    logic [sis_pkg::CNT_W-1:0]         pos_reg, pos_next;
    logic                              found_reg, found_next;
    logic                              present_reg, present_next;
    logic                              ovf_reg, ovf_next;
    logic                              rej_reg, rej_next;
    logic                              first_reg, first_next;

    logic                              last_ptr;
    logic                              is_full;
    logic                              is_ins;
    logic                              ins_skip;
    logic                              pos_at_end;
    logic                              pos_at_top;
    sis_pkg::state_t                   ins_end_state;

    // Shared decision terms.
    always_comb begin
        last_ptr   = (sis_pkg::CNT_W'(ptr_reg + 1'b1) == count_reg);
        is_full    = (count_reg == sis_pkg::CNT_W'(sis_pkg::CAPACITY));
        is_ins     = (kind_reg == sis_pkg::KIND_INSERT) || (kind_reg == sis_pkg::KIND_RANGE);
        ins_skip   = (kind_reg == sis_pkg::KIND_RANGE) && rej_reg;
        pos_at_end = (pos_reg == count_reg);
        pos_at_top = (sis_pkg::CNT_W'(pos_reg + 1'b1) == count_reg);
        ins_end_state = (kind_reg == sis_pkg::KIND_RANGE) ? sis_pkg::ST_RNEXT
                                                          : sis_pkg::ST_REPLY;
    end

    // Compare unit operands: the span check compares end with start,
    // the scan compares the stored entry with the value in hand.
    always_comb begin
        alu_req.b = x_reg;
        alu_req.a = (state_reg == sis_pkg::ST_SPAN) ? e_reg : ram_rd_data;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sis_pkg::ST_IDLE: begin
                if (in_valid) begin
                    unique case (in_kind)
                        sis_pkg::KIND_LOOKUP,
                        sis_pkg::KIND_INSERT,
                        sis_pkg::KIND_REMOVE: state_next = sis_pkg::ST_SCAN_START;
                        sis_pkg::KIND_RANGE:  state_next = sis_pkg::ST_SPAN;
                        default:              state_next = sis_pkg::ST_REPLY;
                    endcase
                end
            end
            sis_pkg::ST_SPAN: state_next = sis_pkg::ST_SCAN_START;
            sis_pkg::ST_SCAN_START: begin
                state_next = (count_reg == '0) ? sis_pkg::ST_ACT : sis_pkg::ST_SCAN;
            end
            sis_pkg::ST_SCAN: begin
                if (!alu_res.lt || last_ptr) begin
                    state_next = sis_pkg::ST_ACT;
                end
            end
            sis_pkg::ST_ACT: begin
                priority if (kind_reg == sis_pkg::KIND_REMOVE) begin
                    if (!found_reg || pos_at_top) begin
                        state_next = sis_pkg::ST_REPLY;
                    end else begin
                        state_next = sis_pkg::ST_SHDN;
                    end
                end else if (is_ins && !ins_skip) begin
                    if (found_reg || is_full || pos_at_end) begin
                        state_next = ins_end_state;
                    end else begin
                        state_next = sis_pkg::ST_SHUP;
                    end
                end else begin
                    state_next = sis_pkg::ST_REPLY;
                end
            end
            sis_pkg::ST_SHUP: begin
                if (ptr_reg == pos_reg) begin
                    state_next = sis_pkg::ST_WRNEW;
                end
            end
            sis_pkg::ST_WRNEW: state_next = ins_end_state;
            sis_pkg::ST_SHDN: begin
                if (last_ptr) begin
                    state_next = sis_pkg::ST_REPLY;
                end
            end
            sis_pkg::ST_RNEXT: begin
                state_next = (x_reg == e_reg) ? sis_pkg::ST_REPLY : sis_pkg::ST_SCAN_START;
            end
            sis_pkg::ST_REPLY: begin
                if (out_free) begin
                    state_next = sis_pkg::ST_IDLE;
                end
            end
            default: state_next = sis_pkg::ST_IDLE;
        endcase
    end

    // Datapath updates, memory requests and handshake outputs.
    always_comb begin
        kind_next    = kind_reg;
        x_next       = x_reg;
        e_next       = e_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        present_next = present_reg;
        ovf_next     = ovf_reg;
        rej_next     = rej_reg;
        first_next   = first_reg;
        ram_req      = '0;
        in_ready     = 1'b0;
        out_load     = 1'b0;

        unique case (state_reg)
            sis_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    kind_next    = in_kind;
                    x_next       = in_value;
                    e_next       = in_end;
                    present_next = 1'b0;
                    ovf_next     = 1'b0;
                    rej_next     = 1'b0;
                    first_next   = 1'b1;
                    if (in_kind == sis_pkg::KIND_CLEAR) begin
                        count_next = '0;
                    end
                end
            end
            sis_pkg::ST_SPAN: begin
                rej_next = alu_res.lt || alu_res.over;
            end
            sis_pkg::ST_SCAN_START: begin
                if (count_reg == '0) begin
                    pos_next   = '0;
                    found_next = 1'b0;
                end else begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = '0;
                    ptr_next        = '0;
                end
            end
            sis_pkg::ST_SCAN: begin
                // Walk up until the first entry not below the value.
                if (alu_res.lt) begin
                    if (last_ptr) begin
                        pos_next   = count_reg;
                        found_next = 1'b0;
                    end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = sis_pkg::ADDR_W'(ptr_reg + 1'b1);
                        ptr_next        = sis_pkg::CNT_W'(ptr_reg + 1'b1);
                    end
                end else begin
                    pos_next   = ptr_reg;
                    found_next = alu_res.eq;
                end
            end
            sis_pkg::ST_ACT: begin
                if (first_reg) begin
                    present_next = found_reg;
                end
                priority if (kind_reg == sis_pkg::KIND_REMOVE) begin
                    if (found_reg) begin
                        if (pos_at_top) begin
                            count_next = sis_pkg::CNT_W'(count_reg - 1'b1);
                        end else begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = sis_pkg::ADDR_W'(pos_reg + 1'b1);
                            ptr_next        = sis_pkg::CNT_W'(pos_reg + 1'b1);
                        end
                    end
                end else if (is_ins && !ins_skip && !found_reg) begin
                    priority if (is_full) begin
                        ovf_next = 1'b1;
                    end else if (pos_at_end) begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = sis_pkg::ADDR_W'(pos_reg);
                        ram_req.wr_data = x_reg;
                        count_next      = sis_pkg::CNT_W'(count_reg + 1'b1);
                    end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = sis_pkg::ADDR_W'(count_reg - 1'b1);
                        ptr_next        = sis_pkg::CNT_W'(count_reg - 1'b1);
                    end
                end else begin
                    ram_req = '0;
                end
            end
            sis_pkg::ST_SHUP: begin
                // Move one entry up, from the top down to the insert point.
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = sis_pkg::ADDR_W'(ptr_reg + 1'b1);
                ram_req.wr_data = ram_rd_data;
                if (ptr_reg != pos_reg) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = sis_pkg::ADDR_W'(ptr_reg - 1'b1);
                    ptr_next        = sis_pkg::CNT_W'(ptr_reg - 1'b1);
                end
            end
            sis_pkg::ST_WRNEW: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = sis_pkg::ADDR_W'(pos_reg);
                ram_req.wr_data = x_reg;
                count_next      = sis_pkg::CNT_W'(count_reg + 1'b1);
            end
            sis_pkg::ST_SHDN: begin
                // Move one entry down, from above the hole to the top.
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = sis_pkg::ADDR_W'(ptr_reg - 1'b1);
                ram_req.wr_data = ram_rd_data;
                if (last_ptr) begin
                    count_next = sis_pkg::CNT_W'(count_reg - 1'b1);
                end else begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = sis_pkg::ADDR_W'(ptr_reg + 1'b1);
                    ptr_next        = sis_pkg::CNT_W'(ptr_reg + 1'b1);
                end
            end
            sis_pkg::ST_RNEXT: begin
                first_next = 1'b0;
                if (x_reg != e_reg) begin
                    x_next = x_reg + 1'b1;
                end
            end
            sis_pkg::ST_REPLY: begin
                out_load = out_free;
            end
            default: begin
                ram_req = '0;
            end
        endcase
    end

    always_comb begin
        out_result.present  = present_reg;
        out_result.count    = sis_pkg::COUNT_W'(count_reg);
        out_result.overflow = ovf_reg;
        out_result.rejected = rej_reg;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sis_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        x_reg       <= x_next;
        e_reg       <= e_next;
        ptr_reg     <= ptr_next;
        pos_reg     <= pos_next;
        found_reg   <= found_next;
        present_reg <= present_next;
        ovf_reg     <= ovf_next;
        rej_reg     <= rej_next;
        first_reg   <= first_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/sis_checker.sv */
`default_nettype none

module sis_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Every operation moves the block out of idle, so no input follows at once.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an operation is in progress");

    // The reported count never exceeds the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:1] <= 7'(sis_pkg::CAPACITY))
        else $error("entry count above capacity");

    // A refused range inserts nothing, so it cannot also overflow.
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[8] && m_tdata[9]))
        else $error("overflow and range refusal reported together");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

endmodule

bind sorted_integer_set_top sis_checker u_sis_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/sv/sorted_integer_set_top_tb.sv */
module sorted_integer_set_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sis_pkg::*;

    // Kinds above the range insert are accepted but change nothing.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    localparam int RANDOM_OPS   = 1950;
    localparam int MAX_GAP      = 14;
    localparam int HOLD_AT      = 300;    // result index that starts the long hold-off
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 300;
    localparam int STALL_LIMIT  = 60000;  // well above the time a full range insert takes

    // One requested set operation.
    typedef struct {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] range_end;
    } set_op_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [7:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // Operations waiting to be sent and results waiting to arrive.
    set_op_t op_queue[$];
    result_t result_queue[$];

    // Shadow copy of the set contents.
    logic signed [DATA_W-1:0] shadow_vals[CAPACITY];
    int                       shadow_count = 0;

    int      errors       = 0;
    int      idle_cycles  = 0;
    set_op_t cur_op;
    int      send_gap     = 0;
    int      sent_ops     = 0;
    bit      send_calm    = 1'b0;
    int      recv_gap     = 0;
    int      hold_left    = 0;
    int      got_results  = 0;
    bit      recv_calm    = 1'b0;

    sorted_integer_set_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Index of the first held entry that is not below v.
    function automatic int lower_index(logic signed [DATA_W-1:0] v);
        int p;
        p = 0;
        while (p < shadow_count && shadow_vals[p] < v) p++;
        return p;
    endfunction

    function automatic bit holds_value(logic signed [DATA_W-1:0] v);
        int p;
        p = lower_index(v);
        return (p < shadow_count) && (shadow_vals[p] == v);
    endfunction

    // Returns 1 when the value had to be dropped because the set is full.
    function automatic bit add_value(logic signed [DATA_W-1:0] v);
        int p;
        p = lower_index(v);
        if (p < shadow_count && shadow_vals[p] == v) return 1'b0;
        if (shadow_count >= CAPACITY) return 1'b1;
        for (int i = shadow_count; i > p; i--) shadow_vals[i] = shadow_vals[i-1];
        shadow_vals[p] = v;
        shadow_count++;
        return 1'b0;
    endfunction

    function automatic void drop_value(logic signed [DATA_W-1:0] v);
        int p;
        p = lower_index(v);
        if (p < shadow_count && shadow_vals[p] == v) begin
            for (int i = p; i < shadow_count - 1; i++) shadow_vals[i] = shadow_vals[i+1];
            shadow_count--;
        end
    endfunction

    // Applies one operation to the shadow set and returns the result it yields.
    function automatic result_t apply_set_op(set_op_t op);
        result_t r;
        longint  span;
        r = '0;
        case (op.kind)
            KIND_LOOKUP: begin
                r.present = holds_value(op.value);
            end
            KIND_INSERT: begin
                r.present  = holds_value(op.value);
                r.overflow = add_value(op.value);
            end
            KIND_REMOVE: begin
                r.present = holds_value(op.value);
                drop_value(op.value);
            end
            KIND_CLEAR: begin
                shadow_count = 0;
            end
            KIND_RANGE: begin
                r.present = holds_value(op.value);
                span = longint'(op.range_end) - longint'(op.value);
                if (span < 0 || span > MAX_RANGE_SPAN) begin
                    r.rejected = 1'b1;
                end else begin
                    for (longint x = op.value; x <= op.range_end; x++)
                        if (add_value(DATA_W'(x))) r.overflow = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = COUNT_W'(shadow_count);
        return r;
    endfunction

    function automatic int draw_gap(bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    task automatic push_op(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] value,
                           logic signed [DATA_W-1:0] range_end);
        set_op_t op;
        op.kind      = kind;
        op.value     = value;
        op.range_end = range_end;
        op_queue.push_back(op);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Sender: presents queued operations with random gaps between transfers.
    always @(posedge aclk) begin : drive_proc
        logic nxt_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            nxt_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                result_queue.push_back(apply_set_op(cur_op));
                sent_ops++;
                if (sent_ops % 64 == 0) send_calm = ($urandom_range(0, 3) == 0);
                send_gap  = draw_gap(send_calm);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (op_queue.size() > 0) begin
                    cur_op    = op_queue.pop_front();
                    s_tdata   <= {cur_op.range_end, cur_op.value};
                    s_tuser   <= {5'b0, cur_op.kind};
                    nxt_valid = 1'b1;
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // Receiver: checks each result transfer and stalls at random.
    always @(posedge aclk) begin : watch_proc
        result_t want;
        logic    nxt_ready;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (result_queue.size() == 0) begin
                    $error("result transfer with none pending: m_tdata=%h", m_tdata);
                    errors++;
                end else begin
                    want = result_queue.pop_front();
                    check_field("present", want.present, m_tdata[0]);
                    check_field("count", want.count, m_tdata[7:1]);
                    check_field("overflow", want.overflow, m_tdata[8]);
                    check_field("range_rejected", want.rejected, m_tdata[9]);
                end
                got_results++;
                // Long hold-off so that the block fills up and stalls its input.
                if (got_results == HOLD_AT) hold_left = HOLD_CYCLES;
                if (got_results % 64 == 0) recv_calm = ($urandom_range(0, 3) == 0);
                recv_gap = draw_gap(recv_calm);
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
            m_tready <= nxt_ready;
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] base;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] range_end;
        int unsigned              width;
        int unsigned              pick;

        // Directed part: extremes, every kind, duplicates, range corner cases.
        push_op(KIND_LOOKUP, 0, 0);
        push_op(KIND_INSERT, INT_MIN, INT_MAX);
        push_op(KIND_INSERT, INT_MAX, INT_MIN);
        push_op(KIND_INSERT, 0, -1);
        push_op(KIND_INSERT, 0, 0);
        push_op(KIND_LOOKUP, INT_MIN, 0);
        push_op(KIND_LOOKUP, -1, 0);
        push_op(KIND_REMOVE, 0, 0);
        push_op(KIND_REMOVE, 0, 0);
        push_op(KIND_RANGE, 10, 20);
        push_op(KIND_RANGE, 10, 12);
        push_op(KIND_RANGE, 50, 49);
        push_op(KIND_RANGE, 1000, 1100);
        push_op(KIND_RANGE, 2000, 2101);
        push_op(KIND_RANGE, INT_MIN, INT_MAX);
        push_op(KIND_RANGE, INT_MAX - 3, INT_MAX);
        for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++) push_op(KIND_W'(k), 7, 9);
        push_op(KIND_CLEAR, 10, 0);
        // Range insert that runs past the capacity, then inserts into the full set.
        push_op(KIND_RANGE, 0, 100);
        push_op(KIND_INSERT, 500, 0);
        push_op(KIND_INSERT, 50, 0);
        push_op(KIND_LOOKUP, 63, 0);
        push_op(KIND_REMOVE, 63, 0);
        push_op(KIND_CLEAR, 0, 0);

        // Random part: values mostly from a narrow pool so that hits and a full set occur.
        base  = 0;
        width = 40;
        for (int i = 0; i < RANDOM_OPS; i++) begin
            if (i % 50 == 0) begin
                width = ($urandom_range(0, 1) == 0) ? 40 : 120;
                case ($urandom_range(0, 4))
                    0: base = 0;
                    1: base = -60;
                    2: base = INT_MIN;
                    3: base = INT_MAX - width;
                    default: base = $urandom;
                endcase
            end
            if ($urandom_range(0, 7) == 0)
                value = $urandom;
            else
                value = base + $urandom_range(0, width);
            range_end = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                kind = KIND_LOOKUP;
            end else if (pick < 55) begin
                kind = KIND_INSERT;
            end else if (pick < 75) begin
                kind = KIND_REMOVE;
            end else if (pick < 87) begin
                kind = KIND_RANGE;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    range_end = value + $urandom_range(0, 8);
                else if (pick < 75)
                    range_end = value + $urandom_range(95, 105);
                else if (pick < 85)
                    range_end = value - 1 - $urandom_range(0, 1000);
            end else if (pick < 90) begin
                kind = KIND_CLEAR;
            end else if (pick < 93) begin
                kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            end else begin
                kind  = KIND_LOOKUP;
                value = $urandom;
            end
            push_op(kind, value, range_end);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every operation is sent and every result has arrived.
        @(negedge aclk);
        while (op_queue.size() != 0 || s_tvalid || result_queue.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/sis_pkg.sv
hw/rtl/sis_ram.sv
hw/rtl/sis_alu.sv
hw/rtl/sis_seq.sv
hw/rtl/sorted_integer_set_top.sv
hw/rtl/sis_checker.sv
tb/sv/sorted_integer_set_top_tb.sv
